### rtl/mcc_pkg.sv
// Shared types, widths and the control program for the mecanum constraint controller.
// Used by every module of the block; depends on nothing else.
package mcc_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int GAIN_W      = 16;
    localparam int INTEG_W     = 32;
    localparam int CFG_IDX_W   = 3;

    // encoder sums: four values added, then negated for the yaw sum
    localparam int SUM_W   = VALUE_WIDTH + 3;
    // arm term (arm_length * wz) >> 8 and integrator >> 8
    localparam int A_W     = VALUE_WIDTH + GAIN_W - 8;
    localparam int E_W     = INTEG_W - 8;
    localparam int CSUM_W  = ((A_W > E_W) ? A_W : E_W) + 2;
    // multiplier: signed operand times zero-extended gain
    localparam int MA_W    = (CSUM_W > SUM_W) ? CSUM_W : SUM_W;
    localparam int PROD_W  = MA_W + GAIN_W + 1;
    // integrator decrement (ct * integral_gain) >> 8 and the difference
    localparam int T_W     = VALUE_WIDTH + GAIN_W - 8;
    localparam int D_W     = ((INTEG_W > T_W) ? INTEG_W : T_W) + 1;

    localparam int NUM_STEPS = 13;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        value_t target_vx;
        value_t target_vy;
        value_t target_wz;
        value_t wheel_speed_fl;
        value_t wheel_speed_fr;
        value_t wheel_speed_br;
        value_t wheel_speed_bl;
        logic   encoders_valid;
    } item_t;

    typedef struct packed {
        value_t wheel_cmd_fl;
        value_t wheel_cmd_fr;
        value_t wheel_cmd_br;
        value_t wheel_cmd_bl;
        value_t measured_vx;
        value_t measured_vy;
        value_t measured_wz;
        value_t constraint_term;
    } result_t;

    // register indexes; also select the multiplier gain operand
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMMAND_GAIN  = 3'd0,
        CFG_ARM_LENGTH    = 3'd1,
        CFG_ENCODER_SCALE = 3'd2,
        CFG_LINEAR_GAIN   = 3'd3,
        CFG_YAW_GAIN      = 3'd4,
        CFG_INTEGRAL_GAIN = 3'd5
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0] RST_COMMAND_GAIN  = 16'd256;
    localparam logic [GAIN_W-1:0] RST_ARM_LENGTH    = 16'd128;
    localparam logic [GAIN_W-1:0] RST_ENCODER_SCALE = 16'd256;
    localparam logic [GAIN_W-1:0] RST_LINEAR_GAIN   = 16'd64;
    localparam logic [GAIN_W-1:0] RST_YAW_GAIN      = 16'd64;
    localparam logic [GAIN_W-1:0] RST_INTEGRAL_GAIN = 16'd983;

    typedef enum logic [3:0] {
        OPA_SX     = 4'd0,
        OPA_SY     = 4'd1,
        OPA_SW     = 4'd2,
        OPA_SC     = 4'd3,
        OPA_WZ     = 4'd4,
        OPA_CT     = 4'd5,
        OPA_CMD_FL = 4'd6,
        OPA_CMD_FR = 4'd7,
        OPA_CMD_BR = 4'd8,
        OPA_CMD_BL = 4'd9
    } opa_t;

    typedef enum logic [3:0] {
        WB_NONE     = 4'd0,
        WB_MVX      = 4'd1,
        WB_MVY      = 4'd2,
        WB_MWZ      = 4'd3,
        WB_CT       = 4'd4,
        WB_ARM_TERM = 4'd5,
        WB_INTEG    = 4'd6,
        WB_CMD_FL   = 4'd7,
        WB_CMD_FR   = 4'd8,
        WB_CMD_BR   = 4'd9,
        WB_CMD_BL   = 4'd10
    } wb_t;

    typedef struct packed {
        opa_t     opa;
        cfg_idx_t gain;
        wb_t      wb;
        logic     skip_if_invalid;
        logic     last;
    } ucode_t;

    typedef struct packed {
        logic   run;
        ucode_t uc;
    } seq_ctl_t;

    // Each step issues one multiply; a step with a writeback target writes back the product issued by the step before.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            4'd0:    w = '{OPA_SX,     CFG_LINEAR_GAIN,   WB_NONE,     1'b1, 1'b0};
            4'd1:    w = '{OPA_SY,     CFG_LINEAR_GAIN,   WB_MVX,      1'b0, 1'b0};
            4'd2:    w = '{OPA_SW,     CFG_YAW_GAIN,      WB_MVY,      1'b0, 1'b0};
            4'd3:    w = '{OPA_SC,     CFG_ENCODER_SCALE, WB_MWZ,      1'b0, 1'b0};
            4'd4:    w = '{OPA_WZ,     CFG_ARM_LENGTH,    WB_CT,       1'b0, 1'b0};
            4'd5:    w = '{OPA_CT,     CFG_INTEGRAL_GAIN, WB_ARM_TERM, 1'b0, 1'b0};
            4'd6:    w = '{OPA_CMD_FL, CFG_COMMAND_GAIN,  WB_INTEG,    1'b0, 1'b0};
            4'd7:    w = '{OPA_CMD_FL, CFG_COMMAND_GAIN,  WB_NONE,     1'b0, 1'b0};
            4'd8:    w = '{OPA_CMD_FR, CFG_COMMAND_GAIN,  WB_CMD_FL,   1'b0, 1'b0};
            4'd9:    w = '{OPA_CMD_BR, CFG_COMMAND_GAIN,  WB_CMD_FR,   1'b0, 1'b0};
            4'd10:   w = '{OPA_CMD_BL, CFG_COMMAND_GAIN,  WB_CMD_BR,   1'b0, 1'b0};
            4'd11:   w = '{OPA_CMD_BL, CFG_COMMAND_GAIN,  WB_CMD_BL,   1'b0, 1'b0};
            4'd12:   w = '{OPA_CMD_BL, CFG_COMMAND_GAIN,  WB_NONE,     1'b0, 1'b1};
            default: w = '{OPA_SX,     CFG_COMMAND_GAIN,  WB_NONE,     1'b0, 1'b1};
        endcase
        return w;
    endfunction

    // clamp a shifted product to the value range
    function automatic value_t sat_value(input logic signed [PROD_W-1:0] x);
        logic [PROD_W-VALUE_WIDTH:0] hi;
        value_t                      r;
        hi = x[PROD_W-1:VALUE_WIDTH-1];
        if (hi == '0 || hi == '1)
        begin
            r = x[VALUE_WIDTH-1:0];
        end
        else if (x[PROD_W-1])
        begin
            r = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/mcc_seq.sv
// Microcode sequencer: step counter, program table lookup and the invalid-encoder jump.
// Depends on mcc_pkg for the control word and the program.
module mcc_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              encoders_ok,
    input  logic              out_free,
    output mcc_pkg::seq_ctl_t ctl,
    output logic              busy,
    output logic              emit
);
    import mcc_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            uc;

    assign uc = ucode_rom(step_reg);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        emit      = 1'b0;
        if (busy_reg)
        begin
            if (uc.skip_if_invalid && !encoders_ok)
            begin
                // drop the item, integrator untouched
                busy_next = 1'b0;
                step_next = '0;
            end
            else if (uc.last)
            begin
                // hold here until the output register is free
                if (out_free)
                begin
                    emit      = 1'b1;
                    busy_next = 1'b0;
                    step_next = '0;
                end
            end
            else
            begin
                step_next = STEP_W'(step_reg + 1'b1);
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctl.run = busy_reg;
    assign ctl.uc  = uc;
    assign busy    = busy_reg;

endmodule

### rtl/mcc_dp.sv
// Datapath: configuration registers, item register, shared multiplier and writeback.
// Depends on mcc_pkg; driven by the control word from mcc_seq.
module mcc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_load,
    input  mcc_pkg::item_t                   item,
    input  mcc_pkg::seq_ctl_t                ctl,
    input  logic                             cfg_we,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcc_pkg::GAIN_W-1:0]       cfg_data,
    output logic                             encoders_ok,
    output mcc_pkg::result_t                 result
);
    import mcc_pkg::*;

    logic [GAIN_W-1:0] command_gain_reg, arm_length_reg, encoder_scale_reg;
    logic [GAIN_W-1:0] linear_gain_reg, yaw_gain_reg, integral_gain_reg;

    item_t                     item_reg;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [A_W-1:0]     arm_term_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    result_t                   res_reg;

    logic signed [SUM_W-1:0]   fl, fr, br, bl, sx, sy, sw, sc;
    logic signed [CSUM_W-1:0]  vx, vy, arm_c, e_c;
    logic signed [E_W-1:0]     e_term;
    logic signed [MA_W-1:0]    opa_val;
    logic [GAIN_W-1:0]         gain_val;
    logic signed [PROD_W-1:0]  sh8, sh16;
    logic signed [T_W-1:0]     dec;
    logic signed [D_W-1:0]     diff;
    logic [D_W-INTEG_W:0]      diff_hi;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_gain_reg  <= RST_COMMAND_GAIN;
            arm_length_reg    <= RST_ARM_LENGTH;
            encoder_scale_reg <= RST_ENCODER_SCALE;
            linear_gain_reg   <= RST_LINEAR_GAIN;
            yaw_gain_reg      <= RST_YAW_GAIN;
            integral_gain_reg <= RST_INTEGRAL_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMMAND_GAIN:  command_gain_reg  <= cfg_data;
                CFG_ARM_LENGTH:    arm_length_reg    <= cfg_data;
                CFG_ENCODER_SCALE: encoder_scale_reg <= cfg_data;
                CFG_LINEAR_GAIN:   linear_gain_reg   <= cfg_data;
                CFG_YAW_GAIN:      yaw_gain_reg      <= cfg_data;
                CFG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign encoders_ok = item_reg.encoders_valid;

    // encoder combinations
    always_comb
    begin
        fl = SUM_W'(item_reg.wheel_speed_fl);
        fr = SUM_W'(item_reg.wheel_speed_fr);
        br = SUM_W'(item_reg.wheel_speed_br);
        bl = SUM_W'(item_reg.wheel_speed_bl);
        sx = fl - fr - br + bl;
        sy = br + bl - fl - fr;
        sw = '0 - (fl + fr + br + bl);
        sc = fl - fr + br - bl;
    end

    // body velocity to wheel sums
    assign e_term = integ_reg[INTEG_W-1:8];
    assign vx     = CSUM_W'(item_reg.target_vx);
    assign vy     = CSUM_W'(item_reg.target_vy);
    assign arm_c  = CSUM_W'(arm_term_reg);
    assign e_c    = CSUM_W'(e_term);

    always_comb
    begin
        case (ctl.uc.opa)
            OPA_SX:     opa_val = MA_W'(sx);
            OPA_SY:     opa_val = MA_W'(sy);
            OPA_SW:     opa_val = MA_W'(sw);
            OPA_SC:     opa_val = MA_W'(sc);
            OPA_WZ:     opa_val = MA_W'(item_reg.target_wz);
            OPA_CT:     opa_val = MA_W'(res_reg.constraint_term);
            OPA_CMD_FL: opa_val = MA_W'(CSUM_W'(vx - vy - arm_c + e_c));
            OPA_CMD_FR: opa_val = MA_W'(CSUM_W'('0 - vx - vy - arm_c - e_c));
            OPA_CMD_BR: opa_val = MA_W'(CSUM_W'(vy - vx - arm_c + e_c));
            OPA_CMD_BL: opa_val = MA_W'(CSUM_W'(vx + vy - arm_c - e_c));
            default:    opa_val = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.uc.gain)
            CFG_COMMAND_GAIN:  gain_val = command_gain_reg;
            CFG_ARM_LENGTH:    gain_val = arm_length_reg;
            CFG_ENCODER_SCALE: gain_val = encoder_scale_reg;
            CFG_LINEAR_GAIN:   gain_val = linear_gain_reg;
            CFG_YAW_GAIN:      gain_val = yaw_gain_reg;
            CFG_INTEGRAL_GAIN: gain_val = integral_gain_reg;
            default:           gain_val = '0;
        endcase
    end

    assign prod_next = PROD_W'(opa_val) * PROD_W'($signed({1'b0, gain_val}));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign sh8  = prod_reg >>> 8;
    assign sh16 = prod_reg >>> 16;

    // integrator step, clamped to 32 bits
    always_comb
    begin
        dec     = sh8[T_W-1:0];
        diff    = D_W'(integ_reg) - D_W'(dec);
        diff_hi = diff[D_W-1:INTEG_W-1];
        if (diff_hi == '0 || diff_hi == '1)
        begin
            integ_next = diff[INTEG_W-1:0];
        end
        else if (diff[D_W-1])
        begin
            integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
        end
        else
        begin
            integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (ctl.run && ctl.uc.wb == WB_INTEG)
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_reg <= item;
        end
        if (ctl.run)
        begin
            case (ctl.uc.wb)
                WB_MVX:      res_reg.measured_vx     <= sat_value(sh8);
                WB_MVY:      res_reg.measured_vy     <= sat_value(sh8);
                WB_MWZ:      res_reg.measured_wz     <= sat_value(sh8);
                WB_CT:       res_reg.constraint_term <= sat_value(sh8);
                WB_ARM_TERM: arm_term_reg            <= sh8[A_W-1:0];
                WB_CMD_FL:   res_reg.wheel_cmd_fl    <= sat_value(sh16);
                WB_CMD_FR:   res_reg.wheel_cmd_fr    <= sat_value(sh16);
                WB_CMD_BR:   res_reg.wheel_cmd_br    <= sat_value(sh16);
                WB_CMD_BL:   res_reg.wheel_cmd_bl    <= sat_value(sh16);
                default:     ;
            endcase
        end
    end

    assign result = res_reg;

endmodule

### rtl/mecanum_constraint_controller.sv
// A new item is taken only once the block is idle again, so items never overlap: the
// 13-step microcode program runs each item on the one shared multiplier.
// An item without valid encoders leaves at the first step of the program, giving no result.
// A waiting result holds the sequencer on its last step until the output register frees.
// Reset (rst_n, async, active low) restores register defaults and clears the integrator.
module mecanum_constraint_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  mcc_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output mcc_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcc_pkg::GAIN_W-1:0]    cfg_data
);
    import mcc_pkg::*;

    seq_ctl_t ctl;
    logic     busy, emit, accept, out_free, encoders_ok;
    result_t  dp_result;
    result_t  result_reg;
    logic     result_valid_reg;

    assign item_stall = busy;
    assign accept     = item_valid && !busy;
    assign out_free   = !result_valid_reg || !result_stall;
    assign cfg_ready  = 1'b1;

    mcc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .encoders_ok (encoders_ok),
        .out_free    (out_free),
        .ctl         (ctl),
        .busy        (busy),
        .emit        (emit)
    );

    mcc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_load   (accept),
        .item        (item),
        .ctl         (ctl),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .encoders_ok (encoders_ok),
        .result      (dp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= dp_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/mcc_checker.sv
// Port-level checks for the mecanum constraint controller, bound to the top level.
// Depends on mcc_pkg for the result type.
module mcc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input mcc_pkg::result_t result
);
    import mcc_pkg::*;

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item accepted but block not busy");

    // a result only appears out of an item in flight
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result without an item in flight");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

endmodule

bind mecanum_constraint_controller mcc_checker u_mcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### tb/testbench.sv
// Self-checking bench for mecanum_constraint_controller: random and corner-case control ticks,
// register writes between phases, and an in-bench kinematics predictor checked per result.
// Depends on rtl/mcc_pkg.sv and rtl/mecanum_constraint_controller.sv.
module testbench;
    import mcc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 30;
    localparam int LONG_HOLD   = 400;
    localparam int NUM_FIELDS  = 8;

    // indexes beyond the register file; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam value_t VMAX = 16'sh7FFF;
    localparam value_t VMIN = 16'sh8000;
    localparam logic [GAIN_W-1:0] GMAX = 16'hFFFF;

    typedef enum int { MIX_RANDOM, MIX_WIND_UP, MIX_WIND_DOWN } mix_t;

    class wheel_cmd_board;
        longint cmd_gain, arm_len, enc_scale, lin_gain, yaw_gain, int_gain;
        longint integral;
        result_t cmd_q[$];
        int errors;
        string field_label[NUM_FIELDS] = '{"wheel_cmd_fl", "wheel_cmd_fr", "wheel_cmd_br",
            "wheel_cmd_bl", "measured_vx", "measured_vy", "measured_wz", "constraint_term"};

        function new();
            cmd_gain  = RST_COMMAND_GAIN;
            arm_len   = RST_ARM_LENGTH;
            enc_scale = RST_ENCODER_SCALE;
            lin_gain  = RST_LINEAR_GAIN;
            yaw_gain  = RST_YAW_GAIN;
            int_gain  = RST_INTEGRAL_GAIN;
            integral  = 0;
            errors    = 0;
        endfunction

        function longint clip(longint x, int w);
            longint hi;
            hi = (longint'(1) << (w - 1)) - 1;
            if (x > hi)
            begin
                return hi;
            end
            if (x < -hi - 1)
            begin
                return -hi - 1;
            end
            return x;
        endfunction

        function value_t wheel_cmd(longint body_sum);
            return value_t'(clip((body_sum * cmd_gain) >>> 16, VALUE_WIDTH));
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            longint v;
            v = longint'(data);
            case (idx)
                CFG_COMMAND_GAIN:  cmd_gain  = v;
                CFG_ARM_LENGTH:    arm_len   = v;
                CFG_ENCODER_SCALE: enc_scale = v;
                CFG_LINEAR_GAIN:   lin_gain  = v;
                CFG_YAW_GAIN:      yaw_gain  = v;
                CFG_INTEGRAL_GAIN: int_gain  = v;
                default: ;
            endcase
        endfunction

        // forward kinematics, integrator update, inverse kinematics
        function void note_item(item_t it);
            longint vx, vy, wz, fl, fr, br, bl, sx, sy, sw, sc, a, e;
            result_t r;
            if (!it.encoders_valid)
            begin
                return;
            end
            vx = it.target_vx;
            vy = it.target_vy;
            wz = it.target_wz;
            fl = it.wheel_speed_fl;
            fr = it.wheel_speed_fr;
            br = it.wheel_speed_br;
            bl = it.wheel_speed_bl;
            sx = fl - fr - br + bl;
            sy = -fl - fr + br + bl;
            sw = -(fl + fr + br + bl);
            sc = fl - fr + br - bl;
            r.measured_vx     = value_t'(clip((sx * lin_gain) >>> 8, VALUE_WIDTH));
            r.measured_vy     = value_t'(clip((sy * lin_gain) >>> 8, VALUE_WIDTH));
            r.measured_wz     = value_t'(clip((sw * yaw_gain) >>> 8, VALUE_WIDTH));
            r.constraint_term = value_t'(clip((sc * enc_scale) >>> 8, VALUE_WIDTH));
            integral = clip(integral - ((longint'(r.constraint_term) * int_gain) >>> 8),
                            INTEG_W);
            a = (arm_len * wz) >>> 8;
            e = integral >>> 8;
            r.wheel_cmd_fl = wheel_cmd(vx - vy - a + e);
            r.wheel_cmd_fr = wheel_cmd(-vx - vy - a - e);
            r.wheel_cmd_br = wheel_cmd(-vx + vy - a + e);
            r.wheel_cmd_bl = wheel_cmd(vx + vy - a - e);
            cmd_q.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            value_t g, w;
            if (cmd_q.size() == 0)
            begin
                report($sformatf("result with no item pending: %h", got));
                return;
            end
            want = cmd_q.pop_front();
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                g = got[(NUM_FIELDS - 1 - i) * VALUE_WIDTH +: VALUE_WIDTH];
                w = want[(NUM_FIELDS - 1 - i) * VALUE_WIDTH +: VALUE_WIDTH];
                if (g !== w)
                begin
                    report($sformatf("%s got %0d expected %0d", field_label[i], g, w));
                end
            end
        endtask

        function int pending();
            return cmd_q.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    item_t            item;
    logic             result_valid;
    logic             result_stall;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;

    wheel_cmd_board board = new();
    bit no_gaps;
    bit hold_off_req;
    int idle_cycles;

    mecanum_constraint_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // predict on accepted items and register writes, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                board.write_reg(cfg_index, cfg_data);
            end
            if (item_valid && !item_stall)
            begin
                board.note_item(item);
            end
            if (result_valid && !result_stall)
            begin
                board.check_result(result);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: stall a random number of cycles before each result, once a long hold-off
    initial
    begin : receiver
        int hold;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            hold = no_gaps ? 0 : $urandom_range(0, 17);
            if (hold_off_req)
            begin
                hold = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
            @(negedge clk);
        end
    end

    function automatic value_t random_value();
        case ($urandom_range(0, 7))
            0:       return VMAX;
            1:       return VMIN;
            2, 3:    return value_t'(int'($urandom_range(0, 511)) - 256);
            default: return value_t'($urandom());
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.target_vx      = random_value();
        it.target_vy      = random_value();
        it.target_wz      = random_value();
        it.wheel_speed_fl = random_value();
        it.wheel_speed_fr = random_value();
        it.wheel_speed_br = random_value();
        it.wheel_speed_bl = random_value();
        it.encoders_valid = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    // push the constraint term hard to one side so the integrator runs into its rail
    function automatic item_t windup_item(bit drive_up);
        item_t it;
        int s;
        s = drive_up ? -1 : 1;
        it = random_item();
        it.wheel_speed_fl = value_t'(s * int'($urandom_range(8192, 32767)));
        it.wheel_speed_fr = value_t'(-s * int'($urandom_range(8192, 32767)));
        it.wheel_speed_br = value_t'(s * int'($urandom_range(8192, 32767)));
        it.wheel_speed_bl = value_t'(-s * int'($urandom_range(8192, 32767)));
        return it;
    endfunction

    function automatic item_t make_item(value_t vx, value_t vy, value_t wz, value_t fl,
                                        value_t fr, value_t br, value_t bl, logic ev);
        item_t it;
        it = '{vx, vy, wz, fl, fr, br, bl, ev};
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] cg, input logic [GAIN_W-1:0] arm,
                              input logic [GAIN_W-1:0] es, input logic [GAIN_W-1:0] lg,
                              input logic [GAIN_W-1:0] yg, input logic [GAIN_W-1:0] ig);
        write_reg(CFG_COMMAND_GAIN, cg);
        write_reg(CFG_ARM_LENGTH, arm);
        write_reg(CFG_ENCODER_SCALE, es);
        write_reg(CFG_LINEAR_GAIN, lg);
        write_reg(CFG_YAW_GAIN, yg);
        write_reg(CFG_INTEGRAL_GAIN, ig);
    endtask

    function automatic logic [GAIN_W-1:0] random_gain();
        return GAIN_W'($urandom_range(0, 65535));
    endfunction

    // let every expected item arrive, then allow for an invalid tick still in flight
    task automatic wait_drain();
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // count every tick sent; ticks without valid encoders are dropped by the block
    task automatic run_ticks(input int count, input mix_t mix);
        item_t it;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            case (mix)
                MIX_WIND_UP:   it = windup_item(1'b1);
                MIX_WIND_DOWN: it = windup_item(1'b0);
                default:       it = random_item();
            endcase
            send_item(it);
            sent++;
        end
        item_valid <= 1'b0;
        wait_drain();
    endtask

    task automatic run_directed();
        item_t list[$];
        list.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 1'b1));
        list.push_back(make_item(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 1'b1));
        list.push_back(make_item(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 1'b1));
        // integrator must hold across ticks without valid encoders
        list.push_back(make_item(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 1'b0));
        list.push_back(make_item(VMAX, VMAX, VMAX, VMAX, VMIN, VMAX, VMIN, 1'b0));
        list.push_back(make_item(VMAX, VMAX, VMAX, 0, 0, 0, 0, 1'b1));
        list.push_back(make_item(VMIN, VMIN, VMIN, 0, 0, 0, 0, 1'b1));
        list.push_back(make_item(0, 0, 0, VMAX, VMIN, VMAX, VMIN, 1'b1));
        list.push_back(make_item(0, 0, 0, VMIN, VMAX, VMIN, VMAX, 1'b1));
        list.push_back(make_item(0, 0, 0, VMAX, VMIN, VMIN, VMAX, 1'b1));
        list.push_back(make_item(0, 0, 0, VMIN, VMAX, VMAX, VMIN, 1'b1));
        list.push_back(make_item(VMAX, VMIN, VMAX, -1, -1, -1, -1, 1'b1));
        list.push_back(make_item(VMIN, VMAX, VMIN, 1, 1, 1, 1, 1'b1));
        list.push_back(make_item(0, 0, VMIN, 0, 0, 0, 0, 1'b1));
        list.push_back(make_item(-1, -1, -1, -1, -1, -1, -1, 1'b1));
        list.push_back(make_item(1, -1, 1, -1, 1, -1, 1, 1'b1));
        list.push_back(make_item(256, -256, 256, 100, -100, 100, -100, 1'b1));
        foreach (list[i])
        begin
            send_item(list[i]);
        end
        item_valid <= 1'b0;
        wait_drain();
    endtask

    initial
    begin : stimulus
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles  = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // spare indexes first: they must leave every gain alone
        write_reg(CFG_SPARE_LO, GMAX);
        write_reg(CFG_SPARE_HI, 16'h0000);
        run_ticks(20, MIX_RANDOM);

        load_gains(GMAX, GMAX, GMAX, GMAX, GMAX, GMAX);
        run_ticks(100, MIX_RANDOM);

        no_gaps = 1'b1;
        load_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_ticks(80, MIX_RANDOM);
        no_gaps = 1'b0;

        load_gains(random_gain(), random_gain(), GMAX,
                   random_gain(), random_gain(), GMAX);
        run_ticks(300, MIX_WIND_UP);
        write_reg(CFG_COMMAND_GAIN, random_gain());
        run_ticks(540, MIX_WIND_DOWN);

        load_gains(random_gain(), random_gain(), random_gain(),
                   random_gain(), random_gain(), random_gain());
        hold_off_req = 1'b1;
        run_ticks(150, MIX_RANDOM);

        load_gains(RST_COMMAND_GAIN, RST_ARM_LENGTH, RST_ENCODER_SCALE,
                   RST_LINEAR_GAIN, RST_YAW_GAIN, RST_INTEGRAL_GAIN);
        no_gaps = 1'b1;
        run_ticks(60, MIX_RANDOM);
        no_gaps = 1'b0;
        run_ticks(80, MIX_RANDOM);

        if (board.pending() != 0)
        begin
            board.report($sformatf("%0d expected items never arrived", board.pending()));
        end
        if (board.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/mcc_pkg.sv
rtl/mcc_seq.sv
rtl/mcc_dp.sv
rtl/mecanum_constraint_controller.sv
rtl/mcc_checker.sv
tb/testbench.sv
